@@ src/rtt_pkg.sv @@
package rtt_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERLAP  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_TOOLONG  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_MAP       = 2'd0,
    CMD_UNMAP     = 2'd1,
    CMD_TRANSLATE = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DISPATCH,
    S_ADD_SCAN,
    S_ADD_WAIT,
    S_ADD_DONE,
    S_LK_SCAN,
    S_LK_WAIT,
    S_LK_DONE,
    S_RM_FETCH,
    S_RM_SPLIT,
    S_RESULT
  } state_t;

endpackage

@@ src/range_translation_table_unit.sv @@
// Range translation table.
//
// A command word is presented on cmd, dev_addr, target_addr, page_bytes and
// page_count and is taken at a rising edge where start is high and busy is
// low. busy rises in the next cycle and stays high until the result word has
// been shown. The result (status, phys_addr, byte_count) appears for exactly
// one cycle with done high; the receiver cannot stall it, and a new command
// may be started in the cycle after done.
//
// Maps, unmaps and translates share one scan sequencer that walks the entry
// table one entry a cycle through a registered memory read port. A map runs
// one insert scan and a translate one lookup scan before the result is
// shown. An unmap runs one lookup per entry it touches plus one insert scan
// for each re-added piece.
//
// Reset clears all valid bits (kept in flip-flops) and the sequencer. Base,
// target and length are held in memories that need no clearing, since an
// entry is only read while its valid bit is set.
module range_translation_table_unit #(
  parameter int ENTRIES   = 64,
  parameter int ADDR_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [47:0] dev_addr,
  input  logic [47:0] target_addr,
  input  logic [30:0] page_bytes,
  input  logic [28:0] page_count,
  output logic        done,
  output logic [2:0]  status,
  output logic [47:0] phys_addr,
  output logic [47:0] byte_count
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = IW + 1;
  localparam int AW = ADDR_BITS + 1;
  localparam logic [AW-1:0] AMASK = {1'b0, {ADDR_BITS{1'b1}}};

  rtt_pkg::state_t state, state_next;

  // Entry store. A tail piece left by an unmap may start past the top of the
  // address space, so bases keep the carry bit.
  logic [ENTRIES-1:0]   valid;
  logic [AW-1:0]        mem_base   [ENTRIES];
  logic [ADDR_BITS-1:0] mem_target [ENTRIES];
  logic [AW-1:0]        mem_len    [ENTRIES];
  logic [AW-1:0]        rd_base;
  logic [AW-1:0]        rd_len;
  logic                 rd_valid;
  logic [IW-1:0]        rd_idx;

  // Command registers.
  rtt_pkg::cmd_t  cmd_r;
  logic [30:0]    pb_r;
  logic [28:0]    pc_r;
  logic [59:0]    prod;
  logic [AW-1:0]  cur_a, cur_len, t_in;

  // Insert operands.
  logic [AW-1:0]  ins_base, ins_len;
  logic [ADDR_BITS-1:0] ins_tgt;
  logic           ins_head_pending; // head piece still to add after tail
  logic [AW-1:0]  head_len;
  logic [AW-1:0]  head_base;
  logic [ADDR_BITS-1:0] head_tgt;
  logic           rm_continue;
  logic [AW-1:0]  next_a, next_len;

  // Scan state.
  logic [CW-1:0]  scan_cnt;
  logic           hit_overlap, slot_found, best_found;
  logic [IW-1:0]  slot_idx, best_idx;
  logic [AW-1:0]  best_base;

  // Entry taken by lookup.
  logic [AW-1:0]  k_base;
  logic [ADDR_BITS-1:0] k_tgt;
  logic [AW-1:0]  k_len;

  rtt_pkg::status_t st_r;
  logic [47:0]    phys_r, cnt_r;

  logic [IW-1:0]  wr_idx;
  logic           wr_en;

  // Memory read, one entry a cycle.
  always_ff @(posedge clk) begin
    rd_base   <= mem_base[scan_cnt[IW-1:0]];
    rd_len    <= mem_len[scan_cnt[IW-1:0]];
    rd_idx    <= scan_cnt[IW-1:0];
    if (wr_en) begin
      mem_base[wr_idx]   <= ins_base;
      mem_target[wr_idx] <= ins_tgt;
      mem_len[wr_idx]    <= ins_len;
    end
  end

  assign wr_idx = slot_idx;
  assign wr_en  = (state == rtt_pkg::S_ADD_DONE) && !hit_overlap && slot_found;

  // Scan step values for the entry just read.
  logic [AW:0] e_end, n_end;
  logic        e_ok;
  always_comb begin
    e_end = {1'b0, rd_base} + {1'b0, rd_len};
    n_end = {1'b0, ins_base} + {1'b0, ins_len};
    e_ok  = rd_valid;
  end

  // Split of the entry found by an unmap lookup.
  logic [AW:0] tail_sh;
  logic [AW:0] r_end, k_end;
  logic        split_tail, split_head;
  always_comb begin
    r_end      = {1'b0, cur_a} + {1'b0, cur_len};
    k_end      = {1'b0, k_base} + {1'b0, k_len};
    tail_sh    = r_end - {1'b0, k_base};
    split_tail = (r_end < k_end);
    split_head = (k_base < cur_a);
  end

  logic scan_last;
  assign scan_last = (scan_cnt == CW'(ENTRIES));

  always_comb begin
    state_next = state;
    unique case (state)
      rtt_pkg::S_IDLE:     if (start) state_next = rtt_pkg::S_MUL;
      rtt_pkg::S_MUL:      state_next = rtt_pkg::S_DISPATCH;
      rtt_pkg::S_DISPATCH: begin
        if ((cmd_r == rtt_pkg::CMD_MAP || cmd_r == rtt_pkg::CMD_UNMAP) &&
            ({1'b0, prod} > 61'(AMASK))) begin
          state_next = rtt_pkg::S_RESULT;
        end else if (cmd_r == rtt_pkg::CMD_MAP) begin
          state_next = rtt_pkg::S_ADD_SCAN;
        end else if (cmd_r == rtt_pkg::CMD_NONE) begin
          state_next = rtt_pkg::S_RESULT;
        end else begin
          state_next = rtt_pkg::S_LK_SCAN;
        end
      end
      rtt_pkg::S_ADD_SCAN: if (scan_last) state_next = rtt_pkg::S_ADD_WAIT;
      rtt_pkg::S_ADD_WAIT: state_next = rtt_pkg::S_ADD_DONE;
      rtt_pkg::S_ADD_DONE: begin
        if (hit_overlap || !slot_found || cmd_r == rtt_pkg::CMD_MAP) begin
          state_next = rtt_pkg::S_RESULT;
        end else if (ins_head_pending) begin
          state_next = rtt_pkg::S_ADD_SCAN;
        end else if (rm_continue) begin
          state_next = rtt_pkg::S_LK_SCAN;
        end else begin
          state_next = rtt_pkg::S_RESULT;
        end
      end
      rtt_pkg::S_LK_SCAN:  if (scan_last) state_next = rtt_pkg::S_LK_WAIT;
      rtt_pkg::S_LK_WAIT:  state_next = rtt_pkg::S_LK_DONE;
      rtt_pkg::S_LK_DONE:  state_next = rtt_pkg::S_RM_FETCH;
      rtt_pkg::S_RM_FETCH: begin
        if (!best_found || ({1'b0, best_base} + {1'b0, k_len}) <= {1'b0, cur_a}) begin
          state_next = rtt_pkg::S_RESULT;
        end else if (cmd_r == rtt_pkg::CMD_TRANSLATE) begin
          state_next = rtt_pkg::S_RESULT;
        end else begin
          state_next = rtt_pkg::S_RM_SPLIT;
        end
      end
      rtt_pkg::S_RM_SPLIT: begin
        if (split_tail || split_head) begin
          state_next = rtt_pkg::S_ADD_SCAN;
        end else if (r_end > k_end) begin
          state_next = rtt_pkg::S_LK_SCAN;
        end else begin
          state_next = rtt_pkg::S_RESULT;
        end
      end
      rtt_pkg::S_RESULT:   state_next = rtt_pkg::S_IDLE;
      default:             state_next = rtt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != rtt_pkg::S_IDLE);
    done       = (state == rtt_pkg::S_RESULT);
    status     = st_r;
    phys_addr  = phys_r;
    byte_count = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rtt_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Read buffer valid bit, registered from scan_cnt like the memory read.
  always_ff @(posedge clk) begin
    rd_valid <= (scan_cnt < CW'(ENTRIES)) ? valid[scan_cnt[IW-1:0]] : 1'b0;
  end

  logic scan_run, rd_run;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_run <= 1'b0;
    end else begin
      rd_run <= scan_run && (scan_cnt < CW'(ENTRIES));
    end
  end
  assign scan_run = (state == rtt_pkg::S_ADD_SCAN) || (state == rtt_pkg::S_LK_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      scan_cnt <= '0;
      st_r     <= rtt_pkg::ST_OK;
      phys_r   <= '0;
      cnt_r    <= '0;
    end else begin
      unique case (state)
        rtt_pkg::S_IDLE: begin
          if (start) begin
            cmd_r <= rtt_pkg::cmd_t'(cmd);
            pb_r  <= page_bytes;
            pc_r  <= page_count;
            cur_a <= AW'(dev_addr) & AMASK;
            t_in  <= AW'(target_addr) & AMASK;
          end
        end
        rtt_pkg::S_MUL: prod <= 60'(pb_r) * 60'(pc_r);
        rtt_pkg::S_DISPATCH: begin
          st_r   <= rtt_pkg::ST_OK;
          phys_r <= '0;
          cnt_r  <= '0;
          scan_cnt <= '0;
          hit_overlap <= 1'b0;
          slot_found  <= 1'b0;
          best_found  <= 1'b0;
          ins_head_pending <= 1'b0;
          rm_continue <= 1'b0;
          if (cmd_r == rtt_pkg::CMD_NONE) begin
            st_r <= rtt_pkg::ST_NOTFOUND;
          end else if ((cmd_r == rtt_pkg::CMD_MAP || cmd_r == rtt_pkg::CMD_UNMAP) &&
                       ({1'b0, prod} > 61'(AMASK))) begin
            st_r <= rtt_pkg::ST_TOOLONG;
          end else begin
            if (cmd_r != rtt_pkg::CMD_TRANSLATE) cnt_r <= prod[47:0];
            cur_len  <= prod[AW-1:0];
            ins_base <= cur_a;
            ins_tgt  <= t_in[ADDR_BITS-1:0];
            ins_len  <= prod[AW-1:0];
          end
        end
        rtt_pkg::S_ADD_SCAN, rtt_pkg::S_ADD_WAIT, rtt_pkg::S_LK_SCAN,
        rtt_pkg::S_LK_WAIT: begin
          if (scan_cnt != CW'(ENTRIES)) scan_cnt <= scan_cnt + CW'(1);
          if (rd_run) begin
            if (state == rtt_pkg::S_ADD_SCAN || state == rtt_pkg::S_ADD_WAIT) begin
              if (e_ok) begin
                if (!(e_end <= {1'b0, ins_base} || {1'b0, rd_base} >= n_end))
                  hit_overlap <= 1'b1;
              end else if (!slot_found) begin
                slot_found <= 1'b1;
                slot_idx   <= rd_idx;
              end
            end else begin
              if (e_ok && rd_base <= cur_a &&
                  (!best_found || rd_base > best_base)) begin
                best_found <= 1'b1;
                best_idx   <= rd_idx;
                best_base  <= rd_base;
              end
            end
          end
        end
        rtt_pkg::S_ADD_DONE: begin
          scan_cnt    <= '0;
          hit_overlap <= 1'b0;
          slot_found  <= 1'b0;
          best_found  <= 1'b0;
          if (hit_overlap) begin
            st_r <= rtt_pkg::ST_OVERLAP;
          end else if (!slot_found) begin
            st_r <= rtt_pkg::ST_FULL;
          end else begin
            valid[slot_idx] <= 1'b1;
            if (ins_head_pending) begin
              ins_head_pending <= 1'b0;
              ins_base <= head_base;
              ins_tgt  <= head_tgt;
              ins_len  <= head_len;
            end else if (rm_continue) begin
              rm_continue <= 1'b0;
              cur_a   <= next_a;
              cur_len <= next_len;
            end
          end
        end
        rtt_pkg::S_LK_DONE: begin
          // Fetch the chosen entry through the second read port.
          k_base <= mem_base[best_idx];
          k_tgt  <= mem_target[best_idx];
          k_len  <= mem_len[best_idx];
        end
        rtt_pkg::S_RM_FETCH: begin
          if (!best_found ||
              ({1'b0, best_base} + {1'b0, k_len}) <= {1'b0, cur_a}) begin
            st_r <= rtt_pkg::ST_NOTFOUND;
          end else if (cmd_r == rtt_pkg::CMD_TRANSLATE) begin
            phys_r <= 48'((cur_a - best_base + AW'(k_tgt)) & AMASK);
          end
        end
        rtt_pkg::S_RM_SPLIT: begin
          valid[best_idx] <= 1'b0;
          scan_cnt    <= '0;
          best_found  <= 1'b0;
          // Tail piece first, then head piece.
          if (split_tail) begin
            ins_base <= AW'(r_end);
            ins_tgt  <= ADDR_BITS'(({1'b0, AW'(k_tgt)} + tail_sh) & {1'b0, AMASK});
            ins_len  <= AW'(k_end - r_end);
            if (split_head) begin
              ins_head_pending <= 1'b1;
              head_base <= k_base;
              head_tgt  <= k_tgt;
              head_len  <= cur_a - k_base;
            end
          end else if (split_head) begin
            ins_base <= k_base;
            ins_tgt  <= k_tgt;
            ins_len  <= cur_a - k_base;
          end
          // The range runs on past this entry: either go straight to the next
          // lookup or pick it up after the head piece is back.
          if (r_end > k_end) begin
            if (split_head) begin
              next_a   <= AW'(k_end);
              next_len <= AW'(r_end - k_end);
              rm_continue <= 1'b1;
            end else begin
              cur_a   <= AW'(k_end);
              cur_len <= AW'(r_end - k_end);
            end
          end
        end
        rtt_pkg::S_RESULT: scan_cnt <= '0;
        default: ;
      endcase
    end
  end

endmodule

@@ bench/range_translation_checker.sv @@
`timescale 1ns / 100ps

// Watches the command and result channels of the range translation table,
// keeps its own copy of the entry table, and compares every result word
// with the prediction made when the command word was taken.
module range_translation_checker #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  cmd,
  input  logic [47:0] dev_addr,
  input  logic [47:0] target_addr,
  input  logic [30:0] page_bytes,
  input  logic [28:0] page_count,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [47:0] phys_addr,
  input  logic [47:0] byte_count,
  output int          mismatches,
  output int          awaited,
  output int          words_checked,
  output int          splits_refused
);

  localparam longint unsigned ADDR_MASK = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct {
    rtt_pkg::status_t st;
    logic [47:0]      phys;
    logic [47:0]      count;
  } table_reply_t;

  table_reply_t replies_due[$];

  logic            slot_used [SLOTS];
  longint unsigned slot_base [SLOTS];
  longint unsigned slot_tgt  [SLOTS];
  longint unsigned slot_len  [SLOTS];

  function automatic rtt_pkg::status_t insert_range(longint unsigned base,
                                                    longint unsigned tgt,
                                                    longint unsigned len);
    int free_slot;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) begin
        if (!(slot_base[i] + slot_len[i] <= base || slot_base[i] >= base + len))
          return rtt_pkg::ST_OVERLAP;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (free_slot < 0) return rtt_pkg::ST_FULL;
    slot_used[free_slot] = 1'b1;
    slot_base[free_slot] = base;
    slot_tgt[free_slot]  = tgt & ADDR_MASK;
    slot_len[free_slot]  = len;
    return rtt_pkg::ST_OK;
  endfunction

  // Entry with the greatest base at or below addr, if it covers addr.
  function automatic int find_entry(longint unsigned addr);
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && slot_base[i] <= addr &&
          (best < 0 || slot_base[i] > slot_base[best]))
        best = i;
    if (best >= 0 && slot_base[best] + slot_len[best] <= addr) return -1;
    return best;
  endfunction

  function automatic rtt_pkg::status_t cut_range(longint unsigned addr,
                                                 longint unsigned len);
    int k;
    longint unsigned b, t, l, e_end, r_end, sh;
    rtt_pkg::status_t st;
    for (int pass = 0; pass < 2 * SLOTS + 2; pass++) begin
      k = find_entry(addr);
      if (k < 0) return rtt_pkg::ST_NOTFOUND;
      b = slot_base[k];
      t = slot_tgt[k];
      l = slot_len[k];
      e_end = b + l;
      r_end = addr + len;
      slot_used[k] = 1'b0;
      // Tail piece goes back first, then the head piece.
      if (r_end < e_end) begin
        sh = r_end - b;
        st = insert_range(b + sh, (t + sh) & ADDR_MASK, l - sh);
        if (st != rtt_pkg::ST_OK) return st;
      end
      if (b < addr) begin
        st = insert_range(b, t, addr - b);
        if (st != rtt_pkg::ST_OK) return st;
      end
      if (r_end <= e_end) return rtt_pkg::ST_OK;
      len  = r_end - e_end;
      addr = e_end;
    end
    return rtt_pkg::ST_OK;
  endfunction

  function automatic table_reply_t predict_reply(rtt_pkg::cmd_t op, longint unsigned addr,
                                                 longint unsigned tgt,
                                                 longint unsigned pb,
                                                 longint unsigned pc);
    table_reply_t r;
    longint unsigned len;
    int k;
    len = pb * pc;
    r.st = rtt_pkg::ST_OK;
    r.phys = '0;
    r.count = '0;
    case (op)
      rtt_pkg::CMD_MAP, rtt_pkg::CMD_UNMAP: begin
        if (len > ADDR_MASK) begin
          r.st = rtt_pkg::ST_TOOLONG;
        end else begin
          r.count = len[47:0];
          r.st = (op == rtt_pkg::CMD_MAP) ? insert_range(addr, tgt, len) :
                                            cut_range(addr, len);
        end
      end
      rtt_pkg::CMD_TRANSLATE: begin
        k = find_entry(addr);
        if (k < 0) r.st = rtt_pkg::ST_NOTFOUND;
        else r.phys = 48'((addr - slot_base[k] + slot_tgt[k]) & ADDR_MASK);
      end
      default: r.st = rtt_pkg::ST_NOTFOUND;
    endcase
    return r;
  endfunction

  initial begin
    mismatches = 0;
    awaited = 0;
    words_checked = 0;
    splits_refused = 0;
  end

  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      replies_due.delete();
    end else begin
      if (done) begin
        words_checked++;
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing outstanding: st=%0d phys=%h cnt=%h",
                     $time, status, phys_addr, byte_count);
        end else begin
          want = replies_due.pop_front();
          if (status !== want.st || phys_addr !== want.phys || byte_count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch st %0d/%0d phys %h/%h cnt %h/%h (expected/actual)",
                       $time, want.st, status, want.phys, phys_addr, want.count,
                       byte_count);
          end
        end
      end
      if (start && !busy) begin
        want = predict_reply(rtt_pkg::cmd_t'(cmd), dev_addr, target_addr, page_bytes,
                             page_count);
        if (rtt_pkg::cmd_t'(cmd) == rtt_pkg::CMD_UNMAP && want.st == rtt_pkg::ST_FULL)
          splits_refused++;
        replies_due.push_back(want);
      end
    end
    awaited = replies_due.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the range translation table. A directed opening
// hits the named corner cases, then a random phase keeps most commands inside
// a small address window so that maps collide, the table fills up, unmaps
// split and chain across entries, and translates mostly hit.
module testbench;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [47:0] dev_addr;
  logic [47:0] target_addr;
  logic [30:0] page_bytes;
  logic [28:0] page_count;
  logic        done;
  logic [2:0]  status;
  logic [47:0] phys_addr;
  logic [47:0] byte_count;

  int mismatches;
  int awaited;
  int words_checked;
  int splits_refused;
  int words_sent;
  int burst_left;

  localparam logic [47:0] WINDOW = 48'h0010_0000_0000;
  localparam logic [47:0] TOP    = 48'hFFFF_FFFF_FFFF;

  range_translation_table_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .dev_addr(dev_addr), .target_addr(target_addr),
    .page_bytes(page_bytes), .page_count(page_count),
    .done(done), .status(status), .phys_addr(phys_addr), .byte_count(byte_count)
  );

  range_translation_checker watch (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .dev_addr(dev_addr), .target_addr(target_addr),
    .page_bytes(page_bytes), .page_count(page_count),
    .done(done), .status(status), .phys_addr(phys_addr), .byte_count(byte_count),
    .mismatches(mismatches), .awaited(awaited), .words_checked(words_checked),
    .splits_refused(splits_refused)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hands one command word to the block. Fields change at the falling edge;
  // the word counts as taken at the first rising edge where busy is low.
  // Between words the sender either keeps start high (inside a burst) or
  // drops it for a random gap, so gaps land on every phase of the busy window.
  task automatic issue_word(rtt_pkg::cmd_t op, logic [47:0] addr, logic [47:0] tgt,
                            logic [30:0] pb, logic [28:0] pc);
    @(negedge clk);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(0, 90)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    start = 1'b1;
    cmd = op;
    dev_addr = addr;
    target_addr = tgt;
    page_bytes = pb;
    page_count = pc;
    do @(posedge clk); while (busy);
    burst_left--;
    words_sent++;
  endtask

  // Random command word. Most words sit in a window of 256 pages of 4 KB so
  // that ranges meet each other; a few are random in every field, which also
  // covers the unused command code and the lengths that are too large.
  task automatic random_word();
    logic [47:0] addr, tgt;
    logic [30:0] pb;
    logic [28:0] pc;
    int pick;
    rtt_pkg::cmd_t op;
    tgt = 48'({$urandom, $urandom});
    if ($urandom_range(0, 99) < 8) begin
      addr = 48'({$urandom, $urandom});
      pb = 31'($urandom);
      pc = 29'($urandom);
      op = rtt_pkg::cmd_t'($urandom_range(0, 3));
    end else begin
      pick = $urandom_range(0, 99);
      op = (pick < 45) ? rtt_pkg::CMD_MAP : (pick < 70) ? rtt_pkg::CMD_UNMAP :
           (pick < 98) ? rtt_pkg::CMD_TRANSLATE : rtt_pkg::CMD_NONE;
      addr = WINDOW + 48'($urandom_range(0, 255)) * 48'd4096;
      if (op == rtt_pkg::CMD_TRANSLATE) addr += 48'($urandom_range(0, 4095));
      pb = ($urandom_range(0, 3) == 0) ? 31'(1 << $urandom_range(0, 14)) : 31'd4096;
      pc = 29'($urandom_range(1, 6));
    end
    issue_word(op, addr, tgt, pb, pc);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = rtt_pkg::CMD_MAP;
    dev_addr = '0;
    target_addr = '0;
    page_bytes = '0;
    page_count = '0;
    words_sent = 0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Lookups on an empty table miss.
    issue_word(rtt_pkg::CMD_TRANSLATE, 48'h1000, '0, '0, '0);
    issue_word(rtt_pkg::CMD_UNMAP, 48'h1000, '0, 31'd4096, 29'd1);
    // A range whose target sits at the top, so translation wraps.
    issue_word(rtt_pkg::CMD_MAP, 48'h1000, 48'hFFFF_FFFF_F000, 31'd4096, 29'd4);
    issue_word(rtt_pkg::CMD_TRANSLATE, 48'h3004, '0, '0, '0);
    // A range inside the first one is refused but still reports its length.
    issue_word(rtt_pkg::CMD_MAP, 48'h2000, 48'h0, 31'd4096, 29'd1);
    // A zero-length range at the base of an entry does not conflict.
    issue_word(rtt_pkg::CMD_MAP, 48'h1000, 48'h55, 31'd0, 29'd9);
    // A range whose end lies beyond the address space.
    issue_word(rtt_pkg::CMD_MAP, TOP - 48'hFFF, 48'hABC, 31'h4000_0000, 29'd1);
    issue_word(rtt_pkg::CMD_TRANSLATE, TOP, '0, '0, '0);
    // Lengths that do not fit in the address width.
    issue_word(rtt_pkg::CMD_MAP, 48'h9000, '0, 31'h4000_0000, 29'h1000_0000);
    issue_word(rtt_pkg::CMD_UNMAP, TOP, TOP, 31'h7FFF_FFFF, 29'h1FFF_FFFF);
    // Unused command code with every bit set.
    issue_word(rtt_pkg::CMD_NONE, TOP, TOP, 31'h7FFF_FFFF, 29'h1FFF_FFFF);
    // Unmap from the middle splits into a tail and a head.
    issue_word(rtt_pkg::CMD_UNMAP, 48'h2000, '0, 31'd4096, 29'd1);
    issue_word(rtt_pkg::CMD_TRANSLATE, 48'h4ABC, '0, '0, '0);
    issue_word(rtt_pkg::CMD_TRANSLATE, 48'h2000, '0, '0, '0);
    // Adjacent range, then a long unmap from the base of the head piece.
    issue_word(rtt_pkg::CMD_MAP, 48'h5000, 48'h7_0000, 31'd4096, 29'd2);
    issue_word(rtt_pkg::CMD_UNMAP, 48'h1000, '0, 31'd4096, 29'd16);
    // Zero-length unmap and a range at address zero.
    issue_word(rtt_pkg::CMD_MAP, 48'h0, 48'h0, 31'd1, 29'd1);
    issue_word(rtt_pkg::CMD_UNMAP, 48'h0, '0, 31'd0, 29'd0);
    issue_word(rtt_pkg::CMD_TRANSLATE, 48'h0, '0, '0, '0);

    repeat (400) random_word();

    @(negedge clk);
    start = 1'b0;
    while (awaited != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d command words and checked %0d result words.", words_sent,
             words_checked);
    $display("Unmaps refused for lack of a free entry while splitting: %0d.",
             splits_refused);
    if (mismatches == 0 && awaited == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run ends far earlier.
  initial begin
    #200_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
